/* rtl/ipb_pkg.sv */
// Shared types, constants and operation codes of the inverse palette builder.
package ipb_pkg;

    localparam int CELL_BITS       = 5;
    localparam int PALETTE_ENTRIES = 256;

    localparam int FUNC_W   = 2;
    localparam int WORD_W   = 32;
    localparam int ENTRY_W  = 8;
    localparam int CELL_W   = 15;
    localparam int DIST_W   = 18;
    localparam int CHAN_W   = 8;

    localparam int RED_LSB   = 2;
    localparam int GREEN_LSB = 13;
    localparam int BLUE_LSB  = 24;

    localparam logic [DIST_W-1:0] DIST_ONES = '1;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [WORD_W-1:0]  color_word;
        logic [ENTRY_W-1:0] entry_index;
        logic [CELL_W-1:0]  cell_req;
    } in_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] result_index;
        logic [DIST_W-1:0]  result_distance;
    } out_t;

endpackage

/* rtl/ipb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module ipb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ipb_cell_dist.sv */
// Squared distance from a colour to a cell centre, with the per-channel squares registered.
module ipb_cell_dist #(
    parameter int CELL_BITS = ipb_pkg::CELL_BITS
) (
    input  logic                         aclk,
    input  logic [ipb_pkg::CHAN_W-1:0]   red,
    input  logic [ipb_pkg::CHAN_W-1:0]   green,
    input  logic [ipb_pkg::CHAN_W-1:0]   blue,
    input  logic [3*CELL_BITS-1:0]       cell_idx,
    output logic [ipb_pkg::DIST_W-1:0]   sq_dist
);

    localparam int CW    = ipb_pkg::CHAN_W;
    localparam int SQ_W  = 2 * CW;
    localparam int SHIFT = CW - CELL_BITS;

    logic [CW-1:0]   centre [3];
    logic [CW-1:0]   chan   [3];
    logic [CW-1:0]   diff   [3];
    logic [SQ_W-1:0] sq_reg [3];
    logic [SQ_W-1:0] sq_next[3];

    assign chan[0] = red;
    assign chan[1] = green;
    assign chan[2] = blue;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            // centre is cell * width + width / 2
            centre[c] = CW'({cell_idx[c*CELL_BITS +: CELL_BITS], 1'b1}) << (SHIFT - 1);
            diff[c]   = (chan[c] >= centre[c]) ? (chan[c] - centre[c]) : (centre[c] - chan[c]);
            sq_next[c] = SQ_W'(diff[c]) * SQ_W'(diff[c]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            sq_reg[c] <= sq_next[c];
        end
    end

    assign sq_dist = ipb_pkg::DIST_W'(sq_reg[0]) + ipb_pkg::DIST_W'(sq_reg[1])
                   + ipb_pkg::DIST_W'(sq_reg[2]);

endmodule

/* rtl/inverse_palette_builder.sv */
// Top level of the inverse palette builder: sequencer, cell memories and result register.
//
//  channel | direction | ports                       | payload
//  --------+-----------+-----------------------------+---------------------------------
//  s_      | in        | s_valid, s_ready, s_data    | func, color_word, entry_index,
//          |           |                             | cell_req
//  m_      | out       | m_valid, m_ready, m_data    | result_index, result_distance
//
// Clear and add walk every cell, one per cycle through the memory port; add also
// waits in ST_FINISH until the last write-back has drained. A lookup reads the
// requested cell and passes through ST_LOOK to ST_FINISH; an unused func code or
// an out-of-range entry goes straight to ST_FINISH.
// After reset a clearing pass over all 2^(3*CELL_BITS) cells (32768) sets every
// distance to all ones and every index to zero; s_ready stays low meanwhile.
// A finished result waits in the output register; the next transfer on s_ is
// taken while it waits, and the sequencer stalls only when a second result is due.
module inverse_palette_builder #(
    parameter int CELL_BITS       = ipb_pkg::CELL_BITS,
    parameter int PALETTE_ENTRIES = ipb_pkg::PALETTE_ENTRIES
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ipb_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ipb_pkg::out_t m_data
);

    localparam int IDX_W   = 3 * CELL_BITS;
    localparam int DEPTH   = 1 << IDX_W;
    localparam int DIST_W  = ipb_pkg::DIST_W;
    localparam int ENTRY_W = ipb_pkg::ENTRY_W;
    localparam int CW      = ipb_pkg::CHAN_W;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CLEAR  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_LOOK   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              pipe_valid_reg, pipe_valid_next;
    logic              m_valid_reg, m_valid_next;

    // payload state
    logic [IDX_W-1:0]   pipe_addr_reg, pipe_addr_next;
    logic [CW-1:0]      red_reg, red_next;
    logic [CW-1:0]      green_reg, green_next;
    logic [CW-1:0]      blue_reg, blue_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    ipb_pkg::out_t      res_reg, res_next;
    ipb_pkg::out_t      out_reg, out_next;

    logic               accept;
    logic               last_cell;
    logic [IDX_W+ipb_pkg::CELL_W-1:0] cell_wide;
    logic [IDX_W-1:0]   req_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [DIST_W-1:0]  dist_rdata;
    logic [ENTRY_W-1:0] idx_rdata;
    logic [DIST_W-1:0]  cand_dist;
    logic               hit;
    logic               dist_we, idx_we;
    logic [IDX_W-1:0]   waddr;
    logic [DIST_W-1:0]  dist_wdata;
    logic [ENTRY_W-1:0] idx_wdata;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign last_cell = &cnt_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // mask the requested cell to the number of cells
    assign cell_wide = {IDX_W'(0), s_data.cell_req};
    assign req_addr  = cell_wide[IDX_W-1:0];

    // read the requested cell on a transfer, otherwise follow the sweep counter
    assign rd_addr = accept ? req_addr : cnt_reg;

    ipb_cell_dist #(
        .CELL_BITS (CELL_BITS)
    ) u_cell_dist (
        .aclk     (aclk),
        .red      (red_reg),
        .green    (green_reg),
        .blue     (blue_reg),
        .cell_idx (cnt_reg),
        .sq_dist  (cand_dist)
    );

    // strictly smaller wins, so on a tie the earlier entry keeps the cell
    assign hit = pipe_valid_reg && (cand_dist < dist_rdata);

    always_comb begin
        dist_we    = 1'b0;
        idx_we     = 1'b0;
        waddr      = cnt_reg;
        dist_wdata = ipb_pkg::DIST_ONES;
        idx_wdata  = '0;
        if (pipe_valid_reg) begin
            waddr      = pipe_addr_reg;
            dist_we    = hit;
            idx_we     = hit;
            dist_wdata = cand_dist;
            idx_wdata  = entry_reg;
        end else if (state_reg == ST_INIT) begin
            dist_we = 1'b1;
            idx_we  = 1'b1;
        end else if (state_reg == ST_CLEAR) begin
            // clear touches distances only
            dist_we = 1'b1;
        end
    end

    ipb_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .aclk  (aclk),
        .we    (dist_we),
        .waddr (waddr),
        .wdata (dist_wdata),
        .raddr (rd_addr),
        .rdata (dist_rdata)
    );

    ipb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_idx_ram (
        .aclk  (aclk),
        .we    (idx_we),
        .waddr (waddr),
        .wdata (idx_wdata),
        .raddr (rd_addr),
        .rdata (idx_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        entry_next      = entry_reg;
        res_next        = res_reg;
        out_next        = out_reg;

        case (state_reg)
            ST_INIT: begin
                // sweep the reset values into both memories
                cnt_next = cnt_reg + 1'b1;
                if (last_cell) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    red_next   = s_data.color_word[ipb_pkg::RED_LSB +: CW];
                    green_next = s_data.color_word[ipb_pkg::GREEN_LSB +: CW];
                    blue_next  = s_data.color_word[ipb_pkg::BLUE_LSB +: CW];
                    entry_next = s_data.entry_index;
                    res_next   = '0;
                    cnt_next   = '0;
                    case (s_data.func)
                        ipb_pkg::FUNC_CLEAR: begin
                            state_next = ST_CLEAR;
                        end
                        ipb_pkg::FUNC_ADD: begin
                            // drop adds whose entry lies beyond the palette
                            if ({1'b0, s_data.entry_index} < (ENTRY_W + 1)'(PALETTE_ENTRIES)) begin
                                state_next = ST_SCAN;
                            end else begin
                                state_next = ST_FINISH;
                            end
                        end
                        ipb_pkg::FUNC_LOOKUP: begin
                            state_next = ST_LOOK;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                cnt_next = cnt_reg + 1'b1;
                if (last_cell) begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                // issue the read of this cell; compare and write back next cycle
                pipe_valid_next = 1'b1;
                pipe_addr_next  = cnt_reg;
                cnt_next        = cnt_reg + 1'b1;
                if (last_cell) begin
                    state_next = ST_FINISH;
                end
            end
            ST_LOOK: begin
                res_next.result_index    = idx_rdata;
                res_next.result_distance = dist_rdata;
                state_next               = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the write-back drains and the output register frees
                if (!pipe_valid_reg && (!m_valid_reg || m_ready)) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            cnt_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pipe_valid_reg <= pipe_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pipe_addr_reg <= pipe_addr_next;
        red_reg       <= red_next;
        green_reg     <= green_next;
        blue_reg      <= blue_next;
        entry_reg     <= entry_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    // a new transfer is never taken while a write-back is still in flight
    a_idle_no_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pipe_valid_reg)
        else $error("transfer accepted with scan write-back pending");

    // an index is only written together with its distance
    a_idx_with_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_we |-> dist_we)
        else $error("index written without distance");

    // a scan write-back follows only a scan cycle
    a_pipe_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_valid_reg |-> ($past(state_reg) == ST_SCAN))
        else $error("write-back without a preceding scan read");

    // a winning distance is always below the unset marker
    a_hit_below_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        hit |-> (dist_wdata != ipb_pkg::DIST_ONES))
        else $error("scan wrote the unset distance");

endmodule

/* test/inverse_palette_builder_tb.sv */
// Self-checking testbench for the inverse palette builder: directed and random palette traffic.
module inverse_palette_builder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ipb_pkg::*;

    // The package has no name for the fourth func code, so give it one here.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    // The longest silent stretch is the clearing pass after reset or one full cell
    // walk plus a receiver stall; allow several times that.
    localparam int WATCHDOG_LIMIT = 150000;
    // This covers anything still in flight at the end.
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_LIMIT   = 10;

    localparam int CELLS      = 1 << (3 * CELL_BITS);
    localparam int CELL_SPAN  = 1 << (CHAN_W - CELL_BITS);
    localparam int CELL_SHIFT = CHAN_W - CELL_BITS;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    inverse_palette_builder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow copy of the cell store: one distance and one palette index
    // per cell, with the reset values of the block.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0]  dist_shadow  [CELLS];
    logic [ENTRY_W-1:0] index_shadow [CELLS];

    initial begin
        for (int k = 0; k < CELLS; k++) begin
            dist_shadow[k]  = DIST_ONES;
            index_shadow[k] = '0;
        end
    end

    // Results the block still owes, oldest first.
    out_t due_results[$];

    int error_count    = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int idle_cycles    = 0;
    logic [WORD_W-1:0] last_color = '0;

    // Apply one request to the shadow store and return the result it must produce.
    function automatic out_t apply_palette_op(in_t req);
        out_t        res;
        int          k;
        int          red, green, blue;
        int          dr, dg, db;
        int unsigned d;
        res   = '0;
        red   = int'(req.color_word[RED_LSB +: CHAN_W]);
        green = int'(req.color_word[GREEN_LSB +: CHAN_W]);
        blue  = int'(req.color_word[BLUE_LSB +: CHAN_W]);
        case (req.func)
            FUNC_CLEAR: begin
                // Only distances go back to all ones; the indexes stay.
                for (k = 0; k < CELLS; k++) dist_shadow[k] = DIST_ONES;
            end
            FUNC_ADD: begin
                if (req.entry_index < PALETTE_ENTRIES) begin
                    for (k = 0; k < CELLS; k++) begin
                        dr = red   - ((k % (1 << CELL_BITS)) * CELL_SPAN + CELL_SPAN / 2);
                        dg = green - (((k >> CELL_BITS) % (1 << CELL_BITS)) * CELL_SPAN
                                      + CELL_SPAN / 2);
                        db = blue  - ((k >> (2 * CELL_BITS)) * CELL_SPAN + CELL_SPAN / 2);
                        d  = dr * dr + dg * dg + db * db;
                        // Strictly smaller only: on a tie the earlier entry keeps the cell.
                        if (d < dist_shadow[k]) begin
                            dist_shadow[k]  = d[DIST_W-1:0];
                            index_shadow[k] = req.entry_index;
                        end
                    end
                end
            end
            FUNC_LOOKUP: begin
                k = req.cell_req & (CELLS - 1);
                res.result_index    = index_shadow[k];
                res.result_distance = dist_shadow[k];
            end
            default: ;  // unused code: no change, zero result
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker. Everything here samples at the rising edge before
    // any nonblocking update lands, so it sees the values of the cycle
    // that just ended. Retire the result transfer first: a result can
    // never belong to a request accepted on the same edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: index %0d distance %0d",
                             m_data.result_index, m_data.result_distance);
            end else begin
                want = due_results.pop_front();
                if (m_data.result_index !== want.result_index ||
                    m_data.result_distance !== want.result_distance) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("mismatch: index exp %0d got %0d, distance exp %0d got %0d",
                                 want.result_index, m_data.result_index,
                                 want.result_distance, m_data.result_distance);
                end
            end
        end
        if (aresetn && s_valid && s_ready)
            due_results.push_back(apply_palette_op(s_data));
    end

    // Receiver: stall at random at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: count cycles without any transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Insert random gaps before raising valid, then hold valid
    // and the payload until the transfer. Valid stays high on exit so a
    // back-to-back request never drops and raises it in one step.
    // ------------------------------------------------------------------
    task automatic issue_request(input logic [FUNC_W-1:0] func,
                                 input logic [WORD_W-1:0] word,
                                 input logic [ENTRY_W-1:0] entry,
                                 input logic [CELL_W-1:0] cell_sel);
        in_t req;
        req.func        = func;
        req.color_word  = word;
        req.entry_index = entry;
        req.cell_req    = cell_sel;
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold off until every owed result has been taken.
    // Advance one edge first so the request accepted on the last edge is queued.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    // Cell that holds the given colour, laid out blue, green, red from the top.
    function automatic logic [CELL_W-1:0] home_cell(logic [WORD_W-1:0] word);
        int red, green, blue;
        red   = int'(word[RED_LSB +: CHAN_W]) >> CELL_SHIFT;
        green = int'(word[GREEN_LSB +: CHAN_W]) >> CELL_SHIFT;
        blue  = int'(word[BLUE_LSB +: CHAN_W]) >> CELL_SHIFT;
        return CELL_W'((blue << (2 * CELL_BITS)) | (green << CELL_BITS) | red);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Freshly reset store: the first and last cells are unset, and the unused code returns zeros.
    task automatic test_reset_state();
        issue_request(FUNC_LOOKUP, $urandom(), ENTRY_W'($urandom()), '0);
        issue_request(FUNC_LOOKUP, $urandom(), ENTRY_W'($urandom()), '1);
        issue_request(FUNC_UNUSED, '1, '1, '1);
    endtask

    // Colours at both corners of the cube with the lowest and highest entries.
    task automatic test_add_extremes();
        issue_request(FUNC_ADD, '0, '0, '0);
        issue_request(FUNC_ADD, '1, '1, '1);
        issue_request(FUNC_LOOKUP, '0, '0, '0);
        issue_request(FUNC_LOOKUP, '1, '1, '1);
        issue_request(FUNC_LOOKUP, '0, '0, CELL_W'(CELLS / 2 + 3));
    endtask

    // Two colours equally far from cell 0: the first one added keeps it,
    // and re-adding an identical colour changes nothing.
    task automatic test_tie_break();
        issue_request(FUNC_CLEAR, $urandom(), ENTRY_W'($urandom()), CELL_W'($urandom()));
        issue_request(FUNC_ADD, '0, 8'd10, '0);
        issue_request(FUNC_ADD, WORD_W'(8) << RED_LSB, 8'd20, '0);
        issue_request(FUNC_ADD, '0, 8'd30, '0);
        issue_request(FUNC_LOOKUP, '0, '0, CELL_W'(0));
        issue_request(FUNC_LOOKUP, '0, '0, CELL_W'(1));
        issue_request(FUNC_LOOKUP, '0, '0, CELL_W'(2));
    endtask

    // Clear resets distances only; the stored indexes survive.
    task automatic test_clear_keeps_index();
        issue_request(FUNC_CLEAR, '1, '1, '1);
        issue_request(FUNC_LOOKUP, '0, '0, CELL_W'(0));
        issue_request(FUNC_LOOKUP, '0, '0, CELL_W'(1));
        wait_for_drain();
    endtask

    // Mostly lookups aimed at cells near the latest colour, with adds,
    // rare clears and the unused code mixed in; four traffic phases.
    task automatic test_random_traffic();
        int pick;
        logic [CELL_W-1:0] look_cell;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 62; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 62; end
                default: begin src_gap_pct = 30; sink_stall_pct = 30; end
            endcase
            for (int n = 0; n < 22; n++) begin
                pick = $urandom_range(99);
                if (pick < 3) begin
                    issue_request(FUNC_CLEAR, $urandom(), ENTRY_W'($urandom()),
                                  CELL_W'($urandom()));
                end else if (pick < 13) begin
                    last_color = $urandom();
                    issue_request(FUNC_ADD, last_color, ENTRY_W'($urandom()),
                                  CELL_W'($urandom()));
                end else if (pick < 20) begin
                    issue_request(FUNC_UNUSED, $urandom(), ENTRY_W'($urandom()),
                                  CELL_W'($urandom()));
                end else begin
                    // Half the lookups land on the latest colour's cell or on one whose index differs in a single bit.
                    look_cell = CELL_W'($urandom());
                    if ($urandom_range(1)) begin
                        look_cell = home_cell(last_color);
                        if ($urandom_range(1))
                            look_cell = look_cell ^ (CELL_W'(1) << $urandom_range(CELL_W - 1));
                    end
                    issue_request(FUNC_LOOKUP, $urandom(), ENTRY_W'($urandom()), look_cell);
                end
            end
            // Let the block run dry once mid-run.
            if (phase == 1)
                wait_for_drain();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // The sender waits for s_ready, which covers the clearing pass.
        test_reset_state();
        test_add_extremes();
        test_tie_break();
        test_clear_keeps_index();
        test_random_traffic();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        error_count += due_results.size();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
